/* rtl/assert_macros.svh */
// assertion macros shared by the filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while out of reset
`define CNV3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define CNV3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/cnv3_pkg.sv */
// package with constants, types and helpers of the 3x3 filter
package cnv3_pkg;

  localparam int MAX_COLS  = 1024;
  localparam int COL_AW    = $clog2(MAX_COLS);
  localparam int PIX_W     = 8;
  localparam int COEF_W    = 8;
  localparam int ROWS_W    = 16;
  localparam int COLS_W    = 11;
  localparam int MASK_W    = 3 * COEF_W;
  localparam int CNT_W     = 27;
  localparam int TOT_W     = ROWS_W + COLS_W;
  localparam int OUT_W     = 20;
  localparam int NORM_W    = 12;
  localparam int DIV_W     = 27;
  localparam int DVS_W     = 11;
  localparam int DIV_CW    = $clog2(DIV_W);
  localparam int PIX_CAP   = 255;
  localparam int NUM_TAPS  = 9;
  localparam int TAP_W     = 4;
  localparam int CFG_IW    = 3;

  localparam logic [CFG_IW-1:0] REG_ROWS   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COLS   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_MASK_T = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MASK_M = 3'd3;
  localparam logic [CFG_IW-1:0] REG_MASK_B = 3'd4;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] idx);
    logic [1:0] r;
    case (idx)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] idx);
    logic [1:0] k;
    case (idx)
      4'd0, 4'd3, 4'd6: k = 2'd0;
      4'd1, 4'd4, 4'd7: k = 2'd1;
      default:          k = 2'd2;
    endcase
    return k;
  endfunction

endpackage

/* rtl/cnv3_div.sv */
// restoring unsigned divider, one quotient bit per cycle
module cnv3_div import cnv3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0]  dvd_q, dvd_d;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DVS_W:0]    rem_sh;
  logic              qbit;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, dvs_q});
    rem_d  = qbit ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
    dvd_d  = {dvd_q[DIV_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule

/* rtl/cnv3_lbuf.sv */
// two line stores packed in one synchronous ram word
module cnv3_lbuf import cnv3_pkg::*; (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [COL_AW-1:0] rd_addr_i,
  output logic [PIX_W-1:0]  rd_upper_o,
  output logic [PIX_W-1:0]  rd_middle_o,
  input  logic              wr_en_i,
  input  logic [COL_AW-1:0] wr_addr_i,
  input  logic [PIX_W-1:0]  wr_upper_i,
  input  logic [PIX_W-1:0]  wr_middle_i
);

  logic [2*PIX_W-1:0] mem [MAX_COLS];
  logic [2*PIX_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_upper_i, wr_middle_i};
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_upper_o  = rd_q[2*PIX_W-1:PIX_W];
  assign rd_middle_o = rd_q[PIX_W-1:0];

endmodule

/* rtl/conv3x3_normalized_filter_top.sv */
// top level of the streaming 3x3 normalized filter
//
//  channel | signals                          | dir
//  in      | operation, pixel_value           | in
//  out     | filtered_value, frame_end        | out
//  cfg     | cfg_index, cfg_data              | in
//
// each input transfer is accepted, then takes the size product, a position divide
// (27 quotient bits), a ram read with window shift and the write back; a flush
// inside the frame is dropped after the divide. one with a result adds the
// multiply-accumulate, a normalize step and, for a nonzero coefficient sum, a divide
// by the same divider, then loads the output register; input is taken only in idle,
// so it stalls until all of this is done. line stores are not cleared after reset.
`include "assert_macros.svh"

module conv3x3_normalized_filter_top import cnv3_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    operation_i,
  input  logic [PIX_W-1:0]        pixel_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] filtered_value_o,
  output logic                    frame_end_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IW-1:0]       cfg_index_i,
  input  logic [MASK_W-1:0]       cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_TOT, S_QDIV, S_RD, S_MAC, S_NRM, S_SDIV, S_OUT
  } state_e;

  state_e                  state_q;
  logic [ROWS_W-1:0]       rows_q;
  logic [COLS_W-1:0]       cols_q;
  logic [MASK_W-1:0]       mask_q [3];
  logic [CNT_W-1:0]        count_q, t_q;
  logic                    op_q;
  logic [PIX_W-1:0]        pix_q, inc_q;
  logic [TOT_W-1:0]        total_q;
  logic [COL_AW-1:0]       wc_q;
  logic                    has_out_q, fend_q;
  logic [CNT_W-1:0]        orow_q;
  logic [COLS_W-1:0]       ocol_q;
  logic [PIX_W-1:0]        win_q [3][3];
  logic [TAP_W-1:0]        idx_q;
  logic signed [PIX_W+COEF_W:0] prod_q;
  logic signed [OUT_W-1:0] acc_q, res_q;
  logic signed [NORM_W-1:0] norm_q;
  logic                    neg_q;
  logic signed [OUT_W-1:0] out_res_q;
  logic                    out_fend_q;

  logic [ROWS_W-1:0]       rows_eff;
  logic [COLS_W-1:0]       cols_eff;
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  logic [PIX_W-1:0]        rd_upper, rd_middle;
  logic                    rd_en;
  logic                    out_load;

  logic [TOT_W:0]          t_x, p_x, tot_x, cols_x;
  logic                    in_frame, keep, has_out;
  logic [CNT_W-1:0]        orow_n;
  logic [COLS_W-1:0]       ocol_n;
  logic [COL_AW-1:0]       wc_n;

  logic [1:0]              tr, tk, wr, wk;
  logic signed [COEF_W-1:0] coef;
  logic [PIX_W-1:0]        tap_pix;
  logic [OUT_W-1:0]        acc_abs;
  logic [NORM_W-1:0]       norm_abs;
  logic signed [OUT_W-1:0] quo_s;

  assign rows_eff = (rows_q == '0) ? ROWS_W'(1) : rows_q;
  always_comb begin
    cols_eff = cols_q;
    if (cols_q == '0) cols_eff = COLS_W'(1);
    if (cols_q > COLS_W'(MAX_COLS)) cols_eff = COLS_W'(MAX_COLS);
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_load    = (state_q == S_OUT) && (!out_valid_o || out_ready_i);

  // position decode from t = q * cols + rem
  always_comb begin
    t_x      = (TOT_W+1)'(t_q);
    tot_x    = {1'b0, total_q};
    cols_x   = (TOT_W+1)'(cols_eff);
    p_x      = t_x - cols_x - 1'b1;
    in_frame = (t_x < tot_x);
    keep     = !(in_frame && (op_q == OP_FLUSH));
    has_out  = (t_x >= cols_x + 1'b1) && (p_x < tot_x);
    wc_n     = div_rsp.remainder[COL_AW-1:0];
    if (div_rsp.remainder != '0) begin
      orow_n = div_rsp.quotient - 1'b1;
      ocol_n = div_rsp.remainder - 1'b1;
    end else begin
      orow_n = div_rsp.quotient - 2'd2;
      ocol_n = cols_eff - 1'b1;
    end
  end

  // tap select with edge clamping
  always_comb begin
    tr = tap_row(idx_q);
    tk = tap_col(idx_q);
    wr = tr;
    wk = tk;
    if ((tr == 2'd0 && orow_q == '0) ||
        (tr == 2'd2 && (orow_q + 1'b1) >= CNT_W'(rows_eff))) begin
      wr = 2'd1;
    end
    if ((tk == 2'd0 && ocol_q == '0) ||
        (tk == 2'd2 && (ocol_q + 1'b1) >= cols_eff)) begin
      wk = 2'd1;
    end
    coef    = $signed(mask_q[tr][tk*COEF_W +: COEF_W]);
    tap_pix = win_q[wr][wk];
  end

  always_comb begin
    acc_abs  = acc_q[OUT_W-1] ? OUT_W'(-acc_q) : OUT_W'(acc_q);
    norm_abs = norm_q[NORM_W-1] ? NORM_W'(-norm_q) : NORM_W'(norm_q);
    quo_s    = neg_q ? -$signed(div_rsp.quotient[OUT_W-1:0])
                     : $signed(div_rsp.quotient[OUT_W-1:0]);
  end

  always_comb begin
    div_req = '0;
    if (state_q == S_TOT) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_W'(t_q);
      div_req.divisor  = DVS_W'(cols_eff);
    end else if (state_q == S_NRM && norm_q != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_W'(acc_abs);
      div_req.divisor  = DVS_W'(norm_abs);
    end
  end

  assign rd_en = (state_q == S_QDIV) && div_rsp.done;

  cnv3_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  cnv3_lbuf u_lbuf (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (wc_n),
    .rd_upper_o  (rd_upper),
    .rd_middle_o (rd_middle),
    .wr_en_i     (state_q == S_RD),
    .wr_addr_i   (wc_q),
    .wr_upper_i  (rd_middle),
    .wr_middle_i (inc_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rows_q      <= ROWS_W'(1);
      cols_q      <= COLS_W'(1);
      mask_q[0]   <= '0;
      mask_q[1]   <= MASK_W'(256);
      mask_q[2]   <= '0;
      count_q     <= '0;
      out_valid_o <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_q[r][k] <= '0;
        end
      end
    end else begin
      if (out_load) begin
        out_valid_o <= 1'b1;
        out_res_q   <= res_q;
        out_fend_q  <= fend_q;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_ROWS:   rows_q    <= cfg_data_i[ROWS_W-1:0];
          REG_COLS:   cols_q    <= cfg_data_i[COLS_W-1:0];
          REG_MASK_T: mask_q[0] <= cfg_data_i;
          REG_MASK_M: mask_q[1] <= cfg_data_i;
          REG_MASK_B: mask_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= operation_i;
            pix_q   <= pixel_value_i;
            t_q     <= count_q;
            state_q <= S_TOT;
          end
        end
        S_TOT: begin
          total_q <= TOT_W'(rows_eff) * TOT_W'(cols_eff);
          state_q <= S_QDIV;
        end
        S_QDIV: begin
          if (div_rsp.done) begin
            if (!keep) begin
              state_q <= S_IDLE;
            end else begin
              inc_q     <= in_frame ? pix_q : '0;
              wc_q      <= wc_n;
              has_out_q <= has_out;
              orow_q    <= orow_n;
              ocol_q    <= ocol_n;
              fend_q    <= (p_x + 1'b1 == tot_x);
              count_q   <= (t_x >= tot_x + cols_x) ? '0 : t_q + 1'b1;
              state_q   <= S_RD;
            end
          end
        end
        S_RD: begin
          for (int r = 0; r < 3; r++) begin
            win_q[r][0] <= win_q[r][1];
            win_q[r][1] <= win_q[r][2];
          end
          win_q[0][2] <= rd_upper;
          win_q[1][2] <= rd_middle;
          win_q[2][2] <= inc_q;
          acc_q       <= '0;
          norm_q      <= '0;
          idx_q       <= '0;
          state_q     <= has_out_q ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          if (idx_q < TAP_W'(NUM_TAPS)) begin
            prod_q <= $signed({1'b0, tap_pix}) * coef;
            norm_q <= norm_q + NORM_W'(coef);
          end
          if (idx_q != '0) begin
            acc_q <= acc_q + OUT_W'(prod_q);
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == TAP_W'(NUM_TAPS)) begin
            state_q <= S_NRM;
          end
        end
        S_NRM: begin
          neg_q <= acc_q[OUT_W-1] ^ norm_q[NORM_W-1];
          if (norm_q == '0) begin
            res_q   <= acc_q;
            state_q <= S_OUT;
          end else begin
            state_q <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (div_rsp.done) begin
            res_q   <= (quo_s > OUT_W'(PIX_CAP)) ? OUT_W'(PIX_CAP) : quo_s;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign filtered_value_o = out_res_q;
  assign frame_end_o      = out_fend_q;

  `CNV3_ASSERT(a_mac_has_out, (state_q == S_MAC) |-> has_out_q, "mac without result")
  `CNV3_ASSERT(a_div_done_state, div_rsp.done |-> (state_q == S_QDIV || state_q == S_SDIV), "stray divide done")
  `CNV3_ASSERT(a_mac_to_nrm, (state_q == S_MAC && idx_q == TAP_W'(NUM_TAPS)) |=> (state_q == S_NRM), "mac length")
  `CNV3_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_res_q)), "held result changed")
  `CNV3_ASSERT_ALWAYS(a_mac_idx, (state_q == S_MAC) |-> (idx_q <= TAP_W'(NUM_TAPS)), "tap index past end")

endmodule

/* bench/filter_checker.sv */
// checker for the 3x3 filter: watches all channels, predicts each result and compares
module filter_checker import cnv3_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    operation_i,
  input  logic [PIX_W-1:0]        pixel_value_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [OUT_W-1:0] filtered_value_i,
  input  logic                    frame_end_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IW-1:0]       cfg_index_i,
  input  logic [MASK_W-1:0]       cfg_data_i,
  output int                      errors_o,
  output int                      pending_o
);

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    frame_end;
  } pixel_result_t;

  pixel_result_t expected_pixels[$];

  logic [ROWS_W-1:0] rows_q;
  logic [COLS_W-1:0] cols_q;
  logic [MASK_W-1:0] mask_q[3];
  logic [PIX_W-1:0]  upper_line[MAX_COLS];
  logic [PIX_W-1:0]  middle_line[MAX_COLS];
  logic [PIX_W-1:0]  window[3][3];
  longint            frame_pos;

  function automatic bit filter_pixel(input logic op, input logic [PIX_W-1:0] px,
                                      output pixel_result_t res);
    longint nrows, ncols, total, t, wc, p, orow, ocol, sum, norm, c;
    logic [PIX_W-1:0] incoming;
    int wr, wk;
    nrows = (rows_q == 0) ? 1 : rows_q;
    ncols = (cols_q == 0) ? 1 : ((cols_q > MAX_COLS) ? MAX_COLS : cols_q);
    total = nrows * ncols;
    t = frame_pos;
    incoming = '0;
    sum = 0;
    norm = 0;
    res.value = '0;
    res.frame_end = 1'b0;
    if (t < total) begin
      if (op == OP_FLUSH) return 1'b0;
      incoming = px;
    end
    wc = t % ncols;
    for (int r = 0; r < 3; r++) begin
      window[r][0] = window[r][1];
      window[r][1] = window[r][2];
    end
    window[0][2] = upper_line[wc];
    window[1][2] = middle_line[wc];
    window[2][2] = incoming;
    upper_line[wc] = middle_line[wc];
    middle_line[wc] = incoming;
    frame_pos = (t >= total + ncols) ? 0 : t + 1;
    if (t < ncols + 1) return 1'b0;
    p = t - ncols - 1;
    if (p >= total) return 1'b0;
    orow = p / ncols;
    ocol = p % ncols;
    for (int r = 0; r < 3; r++) begin
      wr = r;
      if ((r == 0 && orow == 0) || (r == 2 && orow + 1 >= nrows)) wr = 1;
      for (int k = 0; k < 3; k++) begin
        wk = k;
        if ((k == 0 && ocol == 0) || (k == 2 && ocol + 1 >= ncols)) wk = 1;
        c = $signed(mask_q[r][k*COEF_W +: COEF_W]);
        sum += longint'(window[wr][wk]) * c;
        norm += c;
      end
    end
    if (norm != 0) begin
      sum = sum / norm;
      if (sum > PIX_CAP) sum = PIX_CAP;
    end
    res.value = sum[OUT_W-1:0];
    res.frame_end = (p + 1 == total);
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t res, exp_res;
    int err_count;
    if (!rst_ni) begin
      rows_q = 1;
      cols_q = 1;
      mask_q[0] = 0;
      mask_q[1] = 256;
      mask_q[2] = 0;
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (middle_line[i]) middle_line[i] = '0;
      foreach (window[r, k]) window[r][k] = '0;
      frame_pos = 0;
      expected_pixels.delete();
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      err_count = errors_o;
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected output transfer: filtered_value %0d frame_end %0d",
                 filtered_value_i, frame_end_i);
          err_count++;
        end else begin
          exp_res = expected_pixels.pop_front();
          if (filtered_value_i !== exp_res.value) begin
            $error("filtered_value mismatch: expected %0d, actual %0d",
                   exp_res.value, filtered_value_i);
            err_count++;
          end
          if (frame_end_i !== exp_res.frame_end) begin
            $error("frame_end mismatch: expected %0d, actual %0d",
                   exp_res.frame_end, frame_end_i);
            err_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ROWS:   rows_q = cfg_data_i[ROWS_W-1:0];
          REG_COLS:   cols_q = cfg_data_i[COLS_W-1:0];
          REG_MASK_T: mask_q[0] = cfg_data_i;
          REG_MASK_M: mask_q[1] = cfg_data_i;
          REG_MASK_B: mask_q[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (filter_pixel(operation_i, pixel_value_i, res)) begin
          expected_pixels.insert(expected_pixels.size(), res);
        end
      end
      errors_o <= err_count;
      pending_o <= expected_pixels.size();
    end
  end

endmodule

/* bench/tb.sv */
// testbench top for the 3x3 filter: stimulus, handshake idling and verdict
module tb import cnv3_pkg::*;;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_ITEMS   = 550;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    operation_i = OP_PIXEL;
  logic [PIX_W-1:0]        pixel_value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] filtered_value_o;
  logic                    frame_end_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IW-1:0]       cfg_index_i = REG_ROWS;
  logic [MASK_W-1:0]       cfg_data_i = '0;

  int errors;
  int pending;
  int send_idle_pct = 25;
  int recv_idle_pct = 57;
  int items_sent = 0;
  int stall_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  conv3x3_normalized_filter_top u_dut (.*);

  filter_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .pixel_value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .filtered_value_i(filtered_value_o),
    .frame_end_i(frame_end_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input logic op, input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    pixel_value_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [MASK_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_filter(input int nrows, input int ncols, input logic [MASK_W-1:0] top,
                            input logic [MASK_W-1:0] mid, input logic [MASK_W-1:0] bot);
    write_reg(REG_ROWS, MASK_W'(nrows));
    write_reg(REG_COLS, MASK_W'(ncols));
    write_reg(REG_MASK_T, top);
    write_reg(REG_MASK_M, mid);
    write_reg(REG_MASK_B, bot);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(9))
      0, 1:    return '0;
      2, 3:    return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask_row();
    case ($urandom_range(7))
      0:       return 24'h010101;
      1:       return 24'h808080;
      2:       return 24'h7f7f7f;
      3:       return 24'hff08ff;
      4:       return 24'h000000;
      default: return MASK_W'($urandom);
    endcase
  endfunction

  // one full frame plus the flush ticks that drain it, stray flushes mixed in
  task automatic run_frame(input int nrows, input int ncols);
    for (int i = 0; i < nrows * ncols; i++) begin
      if ($urandom_range(19) == 0) send_item(OP_FLUSH, PIX_W'($urandom));
      send_item(OP_PIXEL, pick_pixel());
    end
    for (int i = 0; i <= ncols; i++) begin
      if ($urandom_range(7) == 0) send_item(OP_PIXEL, pick_pixel());
      else send_item(OP_FLUSH, PIX_W'($urandom));
    end
    drain();
  endtask

  initial begin
    int nrows, ncols;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: identity 1x1, stray flush first
    send_item(OP_FLUSH, 8'h00);
    send_item(OP_PIXEL, 8'hff);
    send_item(OP_FLUSH, 8'h00);
    send_item(OP_PIXEL, 8'h5a);
    drain();
    // extreme coefficients, then a zero coefficient sum
    set_filter(2, 2, 24'h808080, 24'h7f7f7f, 24'h808080);
    run_frame(2, 2);
    set_filter(2, 3, 24'hffffff, 24'hff08ff, 24'hffffff);
    run_frame(2, 3);

    // rows that pass the frame end when shrunk mid-frame
    set_filter(65535, 1, 24'h010101, 24'h010101, 24'h010101);
    for (int i = 0; i < 5; i++) send_item(OP_PIXEL, pick_pixel());
    drain();
    write_reg(REG_ROWS, 24'd1);
    send_item(OP_PIXEL, 8'hff);
    drain();

    // out-of-range sizes clamp: zero rows, zero columns, oversized columns
    set_filter(0, 0, pick_mask_row(), pick_mask_row(), pick_mask_row());
    run_frame(1, 1);
    set_filter(0, 2047, pick_mask_row(), pick_mask_row(), pick_mask_row());
    send_item(OP_PIXEL, pick_pixel());
    send_item(OP_PIXEL, pick_pixel());
    drain();
    write_reg(REG_COLS, 24'd1);
    send_item(OP_FLUSH, 8'h00);
    drain();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 57;
      end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 57;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      nrows = $urandom_range(1, 5);
      ncols = $urandom_range(1, 6);
      set_filter(nrows, ncols, pick_mask_row(), pick_mask_row(), pick_mask_row());
      run_frame(nrows, ncols);
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/cnv3_pkg.sv
rtl/cnv3_div.sv
rtl/cnv3_lbuf.sv
rtl/conv3x3_normalized_filter_top.sv
bench/filter_checker.sv
bench/tb.sv
